// ===== hdl/lzwd_pkg.sv =====
// ============================================================================
// lzwd_pkg
// Shared types and constants of the LZ window decompressor.
// ============================================================================
package lzwd_pkg;

    localparam int LANES    = 4;
    localparam int LANE_W   = 2;
    localparam int CNT_W    = 3;
    localparam int WIN_DEPTH = 8192;
    localparam int WIN_AW   = 13;
    localparam int MCNT_W   = 9;

    typedef enum logic [3:0] {
        PH_CMD      = 4'd0,
        PH_CMD2     = 4'd1,
        PH_INL1     = 4'd2,
        PH_INL2     = 4'd3,
        PH_LIT      = 4'd4,
        PH_INL_OFF  = 4'd5,
        PH_FULL_LO  = 4'd6,
        PH_FULL_HI  = 4'd7,
        PH_FULL_EXT = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        CP_IDLE = 2'd0,
        CP_READ = 2'd1,
        CP_DATA = 2'd2,
        CP_PUSH = 2'd3
    } copy_state_t;

    typedef enum logic [1:0] {
        OP_LIT   = 2'd0,
        OP_MATCH = 2'd1,
        OP_END   = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [WIN_AW-1:0] offset;
        logic [MCNT_W-1:0] count;
        logic [7:0]        lit;
    } cmd_t;

    typedef struct packed {
        logic [LANES-1:0][7:0] bytes;
        logic [CNT_W-1:0]      count;
        logic                  last;
        logic                  fin;
    } res_t;

endpackage

// ===== hdl/lzwd_ram.sv =====
// ============================================================================
// lzwd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/lzwd_parser.sv =====
// ============================================================================
// lzwd_parser
// Front end: walks the descriptor bits and turns stream bytes into commands.
// ============================================================================
module lzwd_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_take,
    input  logic [7:0]     in_byte,
    output logic           cmd_valid,
    output lzwd_pkg::cmd_t cmd
);

    typedef struct packed {
        lzwd_pkg::phase_t phase;
        logic [15:0]      desc;
        logic [4:0]       left;
        logic [1:0]       icb;
        logic [lzwd_pkg::MCNT_W-1:0] mcount;
    } bits_t;

    // Consumes descriptor bits while the parser sits in a bit phase; at most
    // four bits are ever taken before a byte phase is reached.
    function automatic bits_t run_bits(input bits_t s_in);
        bits_t s;
        logic  bit_v;
        s = s_in;
        for (int i = 0; i < 4; i++)
        begin
            if (s.left != 5'd0 && (s.phase == lzwd_pkg::PH_CMD || s.phase == lzwd_pkg::PH_CMD2
                || s.phase == lzwd_pkg::PH_INL1 || s.phase == lzwd_pkg::PH_INL2))
            begin
                bit_v  = s.desc[0];
                s.desc = {1'b0, s.desc[15:1]};
                s.left = s.left - 5'd1;
                unique case (s.phase)
                    lzwd_pkg::PH_CMD:
                        s.phase = bit_v ? lzwd_pkg::PH_LIT : lzwd_pkg::PH_CMD2;
                    lzwd_pkg::PH_CMD2:
                        s.phase = bit_v ? lzwd_pkg::PH_FULL_LO : lzwd_pkg::PH_INL1;
                    lzwd_pkg::PH_INL1:
                    begin
                        s.icb   = {bit_v, 1'b0};
                        s.phase = lzwd_pkg::PH_INL2;
                    end
                    default:
                    begin
                        s.icb    = {s.icb[1], bit_v};
                        s.mcount = {{(lzwd_pkg::MCNT_W-2){1'b0}}, s.icb}
                                   + lzwd_pkg::MCNT_W'(2);
                        s.phase  = lzwd_pkg::PH_INL_OFF;
                    end
                endcase
            end
        end
        return s;
    endfunction

    bits_t                       bits_reg, bits_next;
    logic [7:0]                  held_reg, held_next;
    logic                        held_v_reg, held_v_next;
    logic [lzwd_pkg::WIN_AW-1:0] dist_reg, dist_next;
    logic                        done_reg, done_next;

    // Next state.
    always_comb
    begin
        bits_t s;
        s           = bits_reg;
        held_next   = held_reg;
        held_v_next = held_v_reg;
        dist_next   = dist_reg;
        done_next   = done_reg;
        if (in_take && !done_reg)
        begin
            if (bits_reg.left == 5'd0)
            begin
                if (!held_v_reg)
                begin
                    held_next   = in_byte;
                    held_v_next = 1'b1;
                end
                else
                begin
                    s.desc      = {in_byte, held_reg};
                    s.left      = 5'd16;
                    held_v_next = 1'b0;
                    s           = run_bits(s);
                end
            end
            else
            begin
                case (bits_reg.phase)
                    lzwd_pkg::PH_INL_OFF:
                    begin
                        dist_next = {5'h1F, in_byte};
                        s.phase   = lzwd_pkg::PH_CMD;
                    end
                    lzwd_pkg::PH_FULL_LO:
                    begin
                        dist_next = {5'd0, in_byte};
                        s.phase   = lzwd_pkg::PH_FULL_HI;
                    end
                    lzwd_pkg::PH_FULL_HI:
                    begin
                        dist_next = {in_byte[7:3], dist_reg[7:0]};
                        s.phase   = (in_byte[2:0] != 3'd0) ? lzwd_pkg::PH_CMD
                                                           : lzwd_pkg::PH_FULL_EXT;
                    end
                    lzwd_pkg::PH_FULL_EXT:
                    begin
                        done_next = (in_byte == 8'd0);
                        s.phase   = lzwd_pkg::PH_CMD;
                    end
                    default:
                        s.phase = lzwd_pkg::PH_CMD;
                endcase
                if (!(bits_reg.phase == lzwd_pkg::PH_FULL_EXT && in_byte == 8'd0))
                begin
                    s = run_bits(s);
                end
            end
        end
        bits_next = s;
    end

    // Command output.
    always_comb
    begin
        cmd_valid  = 1'b0;
        cmd.op     = lzwd_pkg::OP_LIT;
        cmd.offset = dist_reg;
        cmd.count  = bits_reg.mcount;
        cmd.lit    = in_byte;
        if (in_take && !done_reg && bits_reg.left != 5'd0)
        begin
            case (bits_reg.phase)
                lzwd_pkg::PH_LIT:
                    cmd_valid = 1'b1;
                lzwd_pkg::PH_INL_OFF:
                begin
                    cmd_valid  = 1'b1;
                    cmd.op     = lzwd_pkg::OP_MATCH;
                    cmd.offset = {5'h1F, in_byte};
                end
                lzwd_pkg::PH_FULL_HI:
                begin
                    cmd_valid  = (in_byte[2:0] != 3'd0);
                    cmd.op     = lzwd_pkg::OP_MATCH;
                    cmd.offset = {in_byte[7:3], dist_reg[7:0]};
                    cmd.count  = {6'd0, in_byte[2:0]} + lzwd_pkg::MCNT_W'(2);
                end
                lzwd_pkg::PH_FULL_EXT:
                begin
                    cmd_valid = (in_byte != 8'd1);
                    cmd.op    = (in_byte == 8'd0) ? lzwd_pkg::OP_END : lzwd_pkg::OP_MATCH;
                    cmd.count = {1'b0, in_byte} + lzwd_pkg::MCNT_W'(1);
                end
                default:
                    cmd_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg   <= '{phase: lzwd_pkg::PH_CMD, default: '0};
            held_reg   <= 8'd0;
            held_v_reg <= 1'b0;
            dist_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            bits_reg   <= bits_next;
            held_reg   <= held_next;
            held_v_reg <= held_v_next;
            dist_reg   <= dist_next;
            done_reg   <= done_next;
        end
    end

endmodule

// ===== hdl/lzwd_cmd_queue.sv =====
// ============================================================================
// lzwd_cmd_queue
// Small register queue that decouples the parser from the copy engine.
// ============================================================================
module lzwd_cmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  lzwd_pkg::cmd_t wdata,
    output logic           full,
    input  logic           rd,
    output logic           empty,
    output lzwd_pkg::cmd_t rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lzwd_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]  wp_reg, wp_next;
    logic [PW-1:0]  rp_reg, rp_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (wr)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        end
        if (rd)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        end
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // The count can never pass the depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

// ===== hdl/lzwd_copier.sv =====
// ============================================================================
// lzwd_copier
// Back end: executes commands against the history window and packs bytes.
// ============================================================================
module lzwd_copier (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  lzwd_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           res_valid,
    output lzwd_pkg::res_t res,
    input  logic           res_pop
);

    lzwd_pkg::copy_state_t       state_reg, state_next;
    logic [lzwd_pkg::WIN_AW-1:0] pos_reg, pos_next;
    logic [lzwd_pkg::WIN_AW-1:0] dist_reg, dist_next;
    logic [lzwd_pkg::MCNT_W-1:0] left_reg, left_next;
    logic [lzwd_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic                        is_lit_reg, is_lit_next;
    logic [7:0]                  lit_reg, lit_next;
    logic                        fin_reg, fin_next;
    logic [lzwd_pkg::LANES-1:0][7:0] lane_reg, lane_next;
    logic                        out_v_reg, out_v_next;
    lzwd_pkg::res_t              out_reg, out_next;

    logic                        ram_we;
    logic [lzwd_pkg::WIN_AW-1:0] ram_raddr;
    logic [7:0]                  ram_rdata;
    logic [7:0]                  new_byte;
    logic                        load_ok;

    lzwd_ram #(.WIDTH(8), .DEPTH(lzwd_pkg::WIN_DEPTH)) u_window (
        .clk  (clk),
        .we   (ram_we),
        .waddr(pos_reg),
        .wdata(new_byte),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign load_ok   = !out_v_reg || res_pop;
    assign res_valid = out_v_reg;
    assign res       = out_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzwd_pkg::CP_IDLE:
                if (!q_empty)
                begin
                    if (q_cmd.op == lzwd_pkg::OP_END)
                    begin
                        state_next = lzwd_pkg::CP_PUSH;
                    end
                    else if (q_cmd.op == lzwd_pkg::OP_MATCH)
                    begin
                        state_next = lzwd_pkg::CP_READ;
                    end
                    else
                    begin
                        state_next = lzwd_pkg::CP_DATA;
                    end
                end
            lzwd_pkg::CP_READ:
                state_next = lzwd_pkg::CP_DATA;
            lzwd_pkg::CP_DATA:
                state_next = (left_reg == lzwd_pkg::MCNT_W'(1)
                              || fill_reg == lzwd_pkg::CNT_W'(lzwd_pkg::LANES - 1))
                             ? lzwd_pkg::CP_PUSH : lzwd_pkg::CP_READ;
            lzwd_pkg::CP_PUSH:
                if (load_ok)
                begin
                    state_next = (left_reg == '0) ? lzwd_pkg::CP_IDLE : lzwd_pkg::CP_READ;
                end
            default:
                state_next = lzwd_pkg::CP_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        pos_next    = pos_reg;
        dist_next   = dist_reg;
        left_next   = left_reg;
        fill_next   = fill_reg;
        is_lit_next = is_lit_reg;
        lit_next    = lit_reg;
        fin_next    = fin_reg;
        lane_next   = lane_reg;
        out_next    = out_reg;
        out_v_next  = out_v_reg && !res_pop;
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_raddr   = pos_reg + dist_reg;
        new_byte    = is_lit_reg ? lit_reg : ram_rdata;
        unique case (state_reg)
            lzwd_pkg::CP_IDLE:
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    dist_next   = q_cmd.offset;
                    lit_next    = q_cmd.lit;
                    is_lit_next = (q_cmd.op == lzwd_pkg::OP_LIT);
                    fin_next    = (q_cmd.op == lzwd_pkg::OP_END);
                    fill_next   = '0;
                    if (q_cmd.op == lzwd_pkg::OP_END)
                    begin
                        left_next = '0;
                    end
                    else if (q_cmd.op == lzwd_pkg::OP_LIT)
                    begin
                        left_next = lzwd_pkg::MCNT_W'(1);
                    end
                    else
                    begin
                        left_next = q_cmd.count;
                    end
                end
            lzwd_pkg::CP_READ:
                ram_we = 1'b0;
            lzwd_pkg::CP_DATA:
            begin
                ram_we    = 1'b1;
                pos_next  = pos_reg + lzwd_pkg::WIN_AW'(1);
                lane_next[fill_reg[lzwd_pkg::LANE_W-1:0]] = new_byte;
                fill_next = fill_reg + lzwd_pkg::CNT_W'(1);
                left_next = left_reg - lzwd_pkg::MCNT_W'(1);
            end
            lzwd_pkg::CP_PUSH:
                if (load_ok)
                begin
                    for (int j = 0; j < lzwd_pkg::LANES; j++)
                    begin
                        out_next.bytes[j] = (lzwd_pkg::CNT_W'(j) < fill_reg) ? lane_reg[j]
                                                                             : 8'd0;
                    end
                    out_next.count = fill_reg;
                    out_next.last  = (left_reg == '0);
                    out_next.fin   = fin_reg;
                    out_v_next     = 1'b1;
                    fill_next      = '0;
                    fin_next       = 1'b0;
                end
            default:
                ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
        out_reg  <= out_next;
        dist_reg <= dist_next;
        lit_reg  <= lit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lzwd_pkg::CP_IDLE;
            pos_reg    <= '0;
            left_reg   <= '0;
            fill_reg   <= '0;
            is_lit_reg <= 1'b0;
            fin_reg    <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            left_reg   <= left_next;
            fill_reg   <= fill_next;
            is_lit_reg <= is_lit_next;
            fin_reg    <= fin_next;
            out_v_reg  <= out_v_next;
        end
    end

    // The lane buffer never holds more than one result's worth of bytes.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= lzwd_pkg::CNT_W'(lzwd_pkg::LANES)) else $error("lane overfill");

    // A window read always precedes the data cycle of a match byte.
    a_read_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lzwd_pkg::CP_DATA && !is_lit_reg)
        |-> $past(state_reg) == lzwd_pkg::CP_READ) else $error("match data without read");

    // The end marker result carries no bytes.
    a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_reg.fin) |-> (out_reg.count == '0 && out_reg.last))
        else $error("bad end marker");

    // A pushed result is never overwritten before it is popped.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !res_pop) |=> (out_v_reg && $stable(out_reg)))
        else $error("result lost");

endmodule

// ===== hdl/lz_window_decompressor.sv =====
// ============================================================================
// lz_window_decompressor
// Streaming decoder for descriptor-based LZ data with an 8 KiB window.
// ============================================================================
// Compressed bytes enter one per request through push/full, and decoded bytes
// leave up to four per request through empty/pop, with byte_count telling how
// many lanes are valid, run_last marking the final result caused by one input
// byte, and stream_end marking the single empty result for the end marker.
// Bytes after the end marker are taken and dropped until reset. The parser
// accepts one input byte per cycle whenever the command queue has room.
// The copy engine fetches each command from the queue in its idle state,
// writes each literal byte from the command into the window and its lane,
// handles each match byte as a window read and then the write that also
// places the byte in its lane, and hands each emitted result to the output
// register in a push step that waits while that register still waits for
// pop. It takes no new command until the last result of the current one
// is pushed, so the copy engine, not the parser, sets the sustained rate.
module lz_window_decompressor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte0,
    output logic [7:0] out_byte1,
    output logic [7:0] out_byte2,
    output logic [7:0] out_byte3,
    output logic [2:0] byte_count,
    output logic       run_last,
    output logic       stream_end
);

    logic           take;
    logic           cmd_valid;
    lzwd_pkg::cmd_t cmd;
    logic           q_empty;
    logic           q_pop;
    lzwd_pkg::cmd_t q_cmd;
    logic           res_valid;
    lzwd_pkg::res_t res;

    // A byte is taken whenever the queue can absorb the command it may cause.
    assign take = push && !full;

    lzwd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (take),
        .in_byte  (in_byte),
        .cmd_valid(cmd_valid),
        .cmd      (cmd)
    );

    lzwd_cmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (cmd_valid),
        .wdata(cmd),
        .full (full),
        .rd   (q_pop),
        .empty(q_empty),
        .rdata(q_cmd)
    );

    lzwd_copier u_copier (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .res_valid(res_valid),
        .res      (res),
        .res_pop  (pop)
    );

    assign empty      = !res_valid;
    assign out_byte0  = res.bytes[0];
    assign out_byte1  = res.bytes[1];
    assign out_byte2  = res.bytes[2];
    assign out_byte3  = res.bytes[3];
    assign byte_count = res.count;
    assign run_last   = res.last;
    assign stream_end = res.fin;

endmodule
